>>> sv/encoder_stroke_session_monitor_top_assert.svh
// assertion macros for the stroke session monitor
`ifndef ENCODER_STROKE_SESSION_MONITOR_TOP_ASSERT_SVH
`define ENCODER_STROKE_SESSION_MONITOR_TOP_ASSERT_SVH

// same-cycle implication
`define ESM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("esm check failed");

// next-cycle implication
`define ESM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("esm check failed");

`endif

>>> sv/esm_pkg.sv
package esm_pkg;

	// field widths
	localparam int TIME_W   = 32;
	localparam int POS_W    = 32;
	localparam int CNT_W    = 16;
	localparam int DIST_W   = 48;
	localparam int PULSE_W  = 32;
	localparam int SPEED_W  = 32;
	localparam int LIT_W    = 4;
	localparam int BAND_W   = 2;
	localparam int SEC_W    = 23;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MPP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TMO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd6;

	localparam logic [15:0] MPP_RST   = 16'd2807;
	localparam logic [15:0] PAUSE_RST = 16'd300;
	localparam logic [7:0]  MINP_RST  = 8'd6;
	localparam logic [23:0] TMO_RST   = 24'd30000;
	localparam logic [15:0] WIN_RST   = 16'd1000;
	localparam logic [15:0] CAL_RST   = 16'd7864;
	localparam logic [31:0] STEP_RST  = 32'd21845;

	localparam int LED_COUNT_DEF = 12;
	localparam int LIT_HW_MAX    = 15;

	// reciprocal constants: x/10 = (x*RECIP10) >> 35, x/1000 = (x*RECIP1000) >> 38
	localparam logic [31:0] RECIP10   = 32'd3435973837;
	localparam logic [28:0] RECIP1000 = 29'd274877907;

	// led divider: quotient bits 4 down to 0
	localparam int DIV_STEPS = 5;
	localparam int DIV_CNT_W = 3;

	typedef struct packed {
		logic                 latch;
		logic                 eval;
		logic                 update;
		logic                 div;
		logic                 div_first;
		logic [DIV_CNT_W-1:0] div_bit;
		logic                 load_out;
	} esm_cmd_t;

	typedef struct packed {
		logic               session_active;
		logic               session_ended;
		logic               stroke_done;
		logic [CNT_W-1:0]   stroke_count;
		logic [DIST_W-1:0]  distance_q16;
		logic [DIST_W-1:0]  calories_q16;
		logic [PULSE_W-1:0] total_pulses;
		logic [SPEED_W-1:0] speed_q16;
		logic [SPEED_W-1:0] max_speed_q16;
		logic [LIT_W-1:0]   lit_leds;
		logic [BAND_W-1:0]  effort_band;
		logic [SEC_W-1:0]   duration_s;
	} esm_res_t;

	// floor(7*b/10) for a remainder digit
	function automatic logic [2:0] seven_tenths(input logic [3:0] b);
		logic [2:0] r;
		case (b)
			4'd0, 4'd1: r = 3'd0;
			4'd2:       r = 3'd1;
			4'd3, 4'd4: r = 3'd2;
			4'd5:       r = 3'd3;
			4'd6, 4'd7: r = 3'd4;
			4'd8:       r = 3'd5;
			4'd9:       r = 3'd6;
			default:    r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/esm_ifs.sv
// sample channel
interface esm_in_if;
	import esm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [TIME_W-1:0]       time_ms;
	logic signed [POS_W-1:0] position;
	modport source(output valid, time_ms, position, input ready);
	modport sink(input valid, time_ms, position, output ready);
endinterface

// result channel
interface esm_out_if;
	import esm_pkg::*;
	logic               valid;
	logic               ready;
	logic               session_active;
	logic               session_ended;
	logic               stroke_done;
	logic [CNT_W-1:0]   stroke_count;
	logic [DIST_W-1:0]  distance_q16;
	logic [DIST_W-1:0]  calories_q16;
	logic [PULSE_W-1:0] total_pulses;
	logic [SPEED_W-1:0] speed_q16;
	logic [SPEED_W-1:0] max_speed_q16;
	logic [LIT_W-1:0]   lit_leds;
	logic [BAND_W-1:0]  effort_band;
	logic [SEC_W-1:0]   duration_s;
	modport source(output valid, session_active, session_ended, stroke_done, stroke_count,
		distance_q16, calories_q16, total_pulses, speed_q16, max_speed_q16, lit_leds,
		effort_band, duration_s, input ready);
	modport sink(input valid, session_active, session_ended, stroke_done, stroke_count,
		distance_q16, calories_q16, total_pulses, speed_q16, max_speed_q16, lit_leds,
		effort_band, duration_s, output ready);
endinterface

// configuration write channel
interface esm_cfg_if;
	import esm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/esm_ctrl.sv
module esm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output esm_pkg::esm_cmd_t cmd
);
	import esm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [DIV_CNT_W-1:0] DIV_TOP = DIV_CNT_W'(DIV_STEPS - 1);

	logic [2:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// sequencing of one word through the datapath
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				cnt_d      = DIV_TOP;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div       = 1'b1;
				cmd.div_bit   = cnt_q;
				cmd.div_first = (cnt_q == DIV_TOP);
				if (cnt_q == '0) begin
					state_d = ST_OUT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			// output word held until taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/esm_dp.sv
module esm_dp #(
	parameter int unsigned LED_COUNT = esm_pkg::LED_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  esm_pkg::esm_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [esm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [esm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [esm_pkg::TIME_W-1:0]       time_ms,
	input  logic signed [esm_pkg::POS_W-1:0] position,
	output esm_pkg::esm_res_t                res
);
	import esm_pkg::*;

	localparam int         LIT_MAX  = (LED_COUNT > LIT_HW_MAX) ? LIT_HW_MAX : LED_COUNT;
	localparam logic [4:0] LIT_TOP  = 5'(LIT_MAX);
	localparam logic [3:0] BAND0_HI = 4'd3;
	localparam logic [3:0] BAND1_HI = 4'd6;
	localparam logic [3:0] BAND2_HI = 4'd9;
	localparam logic [1:0] BAND_LOW = 2'd0;
	localparam logic [1:0] BAND_MID = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;
	localparam logic [1:0] BAND_MAX = 2'd3;

	// configuration registers
	logic [15:0] mpp_q, pause_q, win_q, cal_q;
	logic [7:0]  minp_q;
	logic [23:0] tmo_q;
	logic [31:0] step_q;

	// input word
	logic [31:0] t_q, pos_q;

	// session state
	logic [31:0]        ref_q, start_q, act_q, move_q, wtime_q, wpos_q;
	logic               active_q, open_q;
	logic [31:0]        ssum_q;
	logic [SPEED_W-1:0] speed_q, max_q;
	logic [DIST_W-1:0]  dist_q;
	logic [PULSE_W-1:0] pulses_q;
	logic [CNT_W-1:0]   strokes_q;
	logic [SEC_W-1:0]   secs_q;
	logic               done_q, ended_q;

	// evaluation stage
	logic        start_s1, changed_s1, fwd_s1, spd_s1, pause_s1, tmo_s1;
	logic [31:0] d_s1;
	logic [47:0] add_s1, sp_s1;
	logic [28:0] tenth_s1;
	logic [22:0] sec_s1;

	// divider and calories
	logic [31:0]       rem_q;
	logic [4:0]        q_q;
	logic [47:0]       cal_hi_s1;
	logic [31:0]       cal_lo_s1;
	logic [DIST_W-1:0] cal_s2;
	esm_res_t          res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpp_q   <= MPP_RST;
			pause_q <= PAUSE_RST;
			minp_q  <= MINP_RST;
			tmo_q   <= TMO_RST;
			win_q   <= WIN_RST;
			cal_q   <= CAL_RST;
			step_q  <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MPP:   mpp_q   <= cfg_data[15:0];
				REG_PAUSE: pause_q <= cfg_data[15:0];
				REG_MINP:  minp_q  <= cfg_data[7:0];
				REG_TMO:   tmo_q   <= cfg_data[23:0];
				REG_WIN:   win_q   <= cfg_data[15:0];
				REG_CAL:   cal_q   <= cfg_data[15:0];
				REG_STEP:  step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the sample
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			t_q   <= time_ms;
			pos_q <= $unsigned(position);
		end
	end

	// decisions and products of the evaluation cycle
	logic        changed, start, fwd, win_due, pause_due, tmo_due;
	logic [31:0] d, w, mag, et;
	logic [47:0] add_p, sp_p;
	logic [63:0] dec_p;
	logic [60:0] sec_p;

	always_comb begin
		changed   = (pos_q != ref_q);
		start     = changed && !active_q;
		d         = pos_q - ref_q;
		fwd       = changed && active_q && !d[31];
		w         = pos_q - wpos_q;
		mag       = w[31] ? (32'd0 - w) : w;
		et        = start ? 32'd0 : (t_q - start_q);
		win_due   = (t_q - wtime_q) >= {16'd0, win_q};
		pause_due = !changed && open_q && ((t_q - move_q) >= {16'd0, pause_q});
		tmo_due   = !changed && active_q && ((t_q - act_q) > {8'd0, tmo_q});
		add_p     = {16'd0, d} * {32'd0, mpp_q};
		sp_p      = {16'd0, mag} * {32'd0, mpp_q};
		dec_p     = {32'd0, speed_q} * {32'd0, RECIP10};
		sec_p     = {29'd0, et} * {32'd0, RECIP1000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1   <= 1'b0;
			changed_s1 <= 1'b0;
			fwd_s1     <= 1'b0;
			spd_s1     <= 1'b0;
			pause_s1   <= 1'b0;
			tmo_s1     <= 1'b0;
		end else if (cmd.eval) begin
			start_s1   <= start;
			changed_s1 <= changed;
			fwd_s1     <= fwd;
			spd_s1     <= fwd && win_due;
			pause_s1   <= pause_due;
			tmo_s1     <= tmo_due;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			d_s1     <= d;
			add_s1   <= add_p;
			sp_s1    <= sp_p;
			tenth_s1 <= dec_p[63:35];
			sec_s1   <= sec_p[60:38];
		end
	end

	// saturating sums and stroke decay
	logic [48:0]        dist_sum;
	logic [32:0]        pulse_sum, ssum_sum;
	logic [SPEED_W-1:0] sp_sat, decay;
	logic [31:0]        a32, rem10;
	logic               counted_p, counted_t;

	always_comb begin
		dist_sum  = {1'b0, dist_q} + {1'b0, add_s1};
		pulse_sum = {1'b0, pulses_q} + {1'b0, d_s1};
		ssum_sum  = {1'b0, ssum_q} + {1'b0, d_s1};
		sp_sat    = (|sp_s1[47:32]) ? '1 : sp_s1[31:0];
		a32       = {3'd0, tenth_s1};
		rem10     = speed_q - (a32 << 3) - (a32 << 1);
		decay     = (a32 << 3) - a32 + {29'd0, seven_tenths(rem10[3:0])};
		counted_p = pause_s1 && (ssum_q >= {24'd0, minp_q});
		counted_t = tmo_s1 && !pause_s1 && open_q && (ssum_q >= {24'd0, minp_q});
	end

	// state update, in the order movement or pause, duration, timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q     <= '0;
			start_q   <= '0;
			act_q     <= '0;
			move_q    <= '0;
			wtime_q   <= '0;
			wpos_q    <= '0;
			active_q  <= 1'b0;
			open_q    <= 1'b0;
			ssum_q    <= '0;
			speed_q   <= '0;
			max_q     <= '0;
			dist_q    <= '0;
			pulses_q  <= '0;
			strokes_q <= '0;
			secs_q    <= '0;
			done_q    <= 1'b0;
			ended_q   <= 1'b0;
		end else if (cmd.update) begin
			// session start: position becomes the reference
			if (start_s1) begin
				active_q <= 1'b1;
				start_q  <= t_q;
				wtime_q  <= t_q;
				move_q   <= t_q;
				wpos_q   <= pos_q;
				dist_q   <= '0;
				pulses_q <= '0;
				max_q    <= '0;
				speed_q  <= '0;
				open_q   <= 1'b0;
				ssum_q   <= '0;
			end
			// forward movement
			if (fwd_s1) begin
				dist_q   <= dist_sum[48] ? '1 : dist_sum[47:0];
				pulses_q <= pulse_sum[32] ? '1 : pulse_sum[31:0];
				ssum_q   <= ssum_sum[32] ? '1 : ssum_sum[31:0];
				open_q   <= 1'b1;
				move_q   <= t_q;
				if (spd_s1) begin
					speed_q <= sp_sat;
					if (sp_sat > max_q) begin
						max_q <= sp_sat;
					end
					wtime_q <= t_q;
					wpos_q  <= pos_q;
				end
			end
			if (changed_s1) begin
				ref_q <= pos_q;
				act_q <= t_q;
			end
			// stroke closed by a pause
			if (pause_s1) begin
				open_q  <= 1'b0;
				ssum_q  <= '0;
				speed_q <= decay;
			end
			if (active_q || start_s1) begin
				secs_q <= sec_s1;
			end
			// inactivity ends the session
			if (tmo_s1) begin
				open_q   <= 1'b0;
				ssum_q   <= '0;
				active_q <= 1'b0;
				speed_q  <= '0;
			end
			if (start_s1) begin
				strokes_q <= '0;
			end else if ((counted_p || counted_t) && (strokes_q != '1)) begin
				strokes_q <= strokes_q + 1'b1;
			end
			done_q  <= counted_p || counted_t;
			ended_q <= tmo_s1;
		end
	end

	// restoring divider for the led level, one quotient bit a cycle
	logic [31:0] step_e, rem_cur;
	logic [36:0] step_sh, trial;
	logic        ge;
	logic [4:0]  q_base;

	always_comb begin
		step_e  = (step_q == '0) ? 32'd1 : step_q;
		rem_cur = cmd.div_first ? speed_q : rem_q;
		q_base  = cmd.div_first ? 5'd0 : q_q;
		step_sh = {5'd0, step_e} << cmd.div_bit;
		trial   = {5'd0, rem_cur} - step_sh;
		ge      = !trial[36];
	end

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			rem_q <= ge ? trial[31:0] : rem_cur;
			q_q   <= q_base | (5'(ge) << cmd.div_bit);
		end
	end

	// calories from the held distance
	logic [48:0] cal_sum;

	assign cal_sum = {1'b0, cal_hi_s1} + {33'd0, cal_lo_s1[31:16]};

	always_ff @(posedge clk) begin
		cal_hi_s1 <= {16'd0, dist_q[47:16]} * {32'd0, cal_q};
		cal_lo_s1 <= {16'd0, dist_q[15:0]} * {16'd0, cal_q};
		cal_s2    <= cal_sum[48] ? '1 : cal_sum[47:0];
	end

	// led level and effort band
	logic [4:0] lit_full;
	logic [3:0] lit;
	logic [1:0] band;

	always_comb begin
		lit_full = (q_q > LIT_TOP) ? LIT_TOP : q_q;
		lit      = lit_full[3:0];
		if (lit <= BAND0_HI) begin
			band = BAND_LOW;
		end else if (lit <= BAND1_HI) begin
			band = BAND_MID;
		end else if (lit <= BAND2_HI) begin
			band = BAND_HIGH;
		end else begin
			band = BAND_MAX;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.session_active <= active_q;
			res_q.session_ended  <= ended_q;
			res_q.stroke_done    <= done_q;
			res_q.stroke_count   <= strokes_q;
			res_q.distance_q16   <= dist_q;
			res_q.calories_q16   <= cal_s2;
			res_q.total_pulses   <= pulses_q;
			res_q.speed_q16      <= speed_q;
			res_q.max_speed_q16  <= max_q;
			res_q.lit_leds       <= lit;
			res_q.effort_band    <= band;
			res_q.duration_s     <= secs_q;
		end
	end

	assign res = res_q;

endmodule

>>> sv/encoder_stroke_session_monitor_top.sv
// Encoder stroke session monitor.
// sample: one word per encoder reading (time_ms, position), taken on valid and ready.
// result: one word per sample with session flags, stroke count, distance, calories,
//   pulses, speed, peak speed, led level, effort band and duration.
// cfg: register writes by index (0..6), always ready; write only while no sample
//   is in flight. Indexes above 6 are ignored.
// A sample passes through the evaluate and update steps, the five-step led divider
//   (one quotient bit per cycle) and the output load, and no new sample is taken
//   until the block is through with it.
// The result sits in an output register, so the next sample is taken while the
//   previous word waits; if the receiver still stalls once the new word is ready, the
//   block holds the new word in its last step and sample.ready stays low until the register frees.
// Reset (arst_n low) loads the register defaults, clears the session state and
//   drops result.valid; the block is ready for samples once arst_n rises.
`include "encoder_stroke_session_monitor_top_assert.svh"

module encoder_stroke_session_monitor_top #(
	parameter int unsigned LED_COUNT = esm_pkg::LED_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	esm_in_if.sink     sample,
	esm_out_if.source  result,
	esm_cfg_if.sink    cfg
);
	import esm_pkg::*;

	localparam int         LIT_MAX = (LED_COUNT > LIT_HW_MAX) ? LIT_HW_MAX : LED_COUNT;
	localparam logic [3:0] LIT_TOP = 4'(LIT_MAX);

	esm_cmd_t cmd;
	esm_res_t res;
	logic     in_ready, out_valid;

	assign cfg.ready = 1'b1;

	esm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	esm_dp #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.time_ms   (sample.time_ms),
		.position  (sample.position),
		.res       (res)
	);

	// channel hookup
	assign sample.ready          = in_ready;
	assign result.valid          = out_valid;
	assign result.session_active = res.session_active;
	assign result.session_ended  = res.session_ended;
	assign result.stroke_done    = res.stroke_done;
	assign result.stroke_count   = res.stroke_count;
	assign result.distance_q16   = res.distance_q16;
	assign result.calories_q16   = res.calories_q16;
	assign result.total_pulses   = res.total_pulses;
	assign result.speed_q16      = res.speed_q16;
	assign result.max_speed_q16  = res.max_speed_q16;
	assign result.lit_leds       = res.lit_leds;
	assign result.effort_band    = res.effort_band;
	assign result.duration_s     = res.duration_s;

	// checks
	`ESM_ASSERT_IMP(a_end_clears_active, clk, arst_n, result.valid && result.session_ended, !result.session_active)
	`ESM_ASSERT_IMP(a_peak_covers_speed, clk, arst_n, result.valid, result.max_speed_q16 >= result.speed_q16)
	`ESM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, sample.valid && sample.ready, !sample.ready)
	`ESM_ASSERT_IMP(a_lit_in_range, clk, arst_n, result.valid, result.lit_leds <= LIT_TOP)

endmodule

>>> verif/esm_session_checker.sv
`timescale 1ns / 1ps

module esm_session_checker #(
	parameter int unsigned LED_COUNT = esm_pkg::LED_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	esm_in_if    sample,
	esm_out_if   result,
	esm_cfg_if   cfg,
	output int   failures,
	output int   outstanding,
	output int   words_checked,
	output int   sessions_closed,
	output int   strokes_counted
);
	import esm_pkg::*;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [31:0]       U32_MAX  = 32'hFFFF_FFFF;
	localparam logic [SEC_W-1:0]  SEC_MAX  = '1;

	localparam logic [BAND_W-1:0] BAND_EASY   = 2'd0;
	localparam logic [BAND_W-1:0] BAND_STEADY = 2'd1;
	localparam logic [BAND_W-1:0] BAND_HARD   = 2'd2;
	localparam logic [BAND_W-1:0] BAND_ALL    = 2'd3;

	// register copies
	logic [15:0] mpp_r, pause_r, win_r, cal_r;
	logic [7:0]  minp_r;
	logic [23:0] tmo_r;
	logic [31:0] step_r;

	// session state
	logic [31:0]       ref_pos, start_t, act_t, move_t, win_t, win_pos;
	logic [31:0]       speed_r, peak_r, pulse_r, stroke_sum;
	logic              active, stroke_open;
	logic [DIST_W-1:0] dist_r;
	logic [CNT_W-1:0]  strokes_r;
	logic [SEC_W-1:0]  secs_r;

	esm_res_t predicted_words[$];
	esm_res_t got, want;

	task automatic report_mismatch(input string what, input logic [63:0] seen,
		input logic [63:0] wanted);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
			$time, what, seen, wanted);
		failures++;
	endtask

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? U32_MAX : s[31:0];
	endfunction

	// close the open stroke, true when it had enough pulses to count
	function automatic logic finish_stroke();
		logic counted;
		counted = stroke_open && (stroke_sum >= 32'(minp_r));
		if (counted && strokes_r != 16'hFFFF) begin
			strokes_r = strokes_r + 16'd1;
		end
		stroke_open = 1'b0;
		stroke_sum  = '0;
		return counted;
	endfunction

	function automatic logic [DIST_W-1:0] kcal_of(input logic [DIST_W-1:0] d);
		logic [63:0] r;
		r = 64'(d[47:16]) * 64'(cal_r) + ((64'(d[15:0]) * 64'(cal_r)) >> 16);
		return (r > 64'(DIST_MAX)) ? DIST_MAX : r[47:0];
	endfunction

	// one encoder sample in, the result word it must produce
	function automatic esm_res_t advance_session(input logic [31:0] t, input logic [31:0] pos);
		esm_res_t    w;
		logic [31:0] d, dw, mag, elapsed, secs32;
		logic [63:0] prod, lit64, step64;
		logic [48:0] dsum;
		logic        ended, done;
		ended = 1'b0;
		done  = 1'b0;
		if (pos != ref_pos) begin
			// first change while idle opens a session at this position
			if (!active) begin
				active      = 1'b1;
				start_t     = t;
				act_t       = t;
				win_t       = t;
				move_t      = t;
				dist_r      = '0;
				pulse_r     = '0;
				strokes_r   = '0;
				peak_r      = '0;
				speed_r     = '0;
				secs_r      = '0;
				stroke_open = 1'b0;
				stroke_sum  = '0;
				ref_pos     = pos;
				win_pos     = pos;
			end
			d = pos - ref_pos;
			// forward move: distance, pulses, stroke, speed window
			if (d != 32'd0 && !d[31]) begin
				prod        = 64'(d) * 64'(mpp_r);
				dsum        = {1'b0, dist_r} + prod[48:0];
				dist_r      = (dsum > 49'(DIST_MAX)) ? DIST_MAX : dsum[47:0];
				pulse_r     = sat_add32(pulse_r, d);
				stroke_sum  = sat_add32(stroke_sum, d);
				stroke_open = 1'b1;
				move_t      = t;
				elapsed     = t - win_t;
				if (elapsed >= 32'(win_r)) begin
					dw      = pos - win_pos;
					mag     = dw[31] ? (32'd0 - dw) : dw;
					prod    = 64'(mag) * 64'(mpp_r);
					speed_r = (prod > 64'(U32_MAX)) ? U32_MAX : prod[31:0];
					if (speed_r > peak_r) begin
						peak_r = speed_r;
					end
					win_t   = t;
					win_pos = pos;
				end
			end
			ref_pos = pos;
			act_t   = t;
		end else begin
			// stillness long enough closes the stroke and decays speed
			elapsed = t - move_t;
			if (stroke_open && elapsed >= 32'(pause_r)) begin
				done    = finish_stroke();
				prod    = (64'(speed_r) * 64'd7) / 64'd10;
				speed_r = prod[31:0];
			end
		end

		// duration
		if (active) begin
			secs32 = (t - start_t) / 32'd1000;
			secs_r = (secs32 > 32'(SEC_MAX)) ? SEC_MAX : secs32[SEC_W-1:0];
		end

		// inactivity ends the session
		elapsed = t - act_t;
		if (active && elapsed > 32'(tmo_r)) begin
			if (finish_stroke()) begin
				done = 1'b1;
			end
			active  = 1'b0;
			speed_r = '0;
			ended   = 1'b1;
		end

		// led level and effort band
		step64 = (step_r == 32'd0) ? 64'd1 : 64'(step_r);
		lit64  = 64'(speed_r) / step64;
		if (lit64 > 64'(LED_COUNT)) begin
			lit64 = 64'(LED_COUNT);
		end
		if (lit64 > 64'(LIT_HW_MAX)) begin
			lit64 = 64'(LIT_HW_MAX);
		end

		w.session_active = active;
		w.session_ended  = ended;
		w.stroke_done    = done;
		w.stroke_count   = strokes_r;
		w.distance_q16   = dist_r;
		w.calories_q16   = kcal_of(dist_r);
		w.total_pulses   = pulse_r;
		w.speed_q16      = speed_r;
		w.max_speed_q16  = peak_r;
		w.lit_leds       = lit64[LIT_W-1:0];
		w.effort_band    = (lit64 <= 3) ? BAND_EASY : (lit64 <= 6) ? BAND_STEADY :
			(lit64 <= 9) ? BAND_HARD : BAND_ALL;
		w.duration_s     = secs_r;
		return w;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpp_r       = MPP_RST;
			pause_r     = PAUSE_RST;
			minp_r      = MINP_RST;
			tmo_r       = TMO_RST;
			win_r       = WIN_RST;
			cal_r       = CAL_RST;
			step_r      = STEP_RST;
			ref_pos     = '0;
			start_t     = '0;
			act_t       = '0;
			move_t      = '0;
			win_t       = '0;
			win_pos     = '0;
			speed_r     = '0;
			peak_r      = '0;
			pulse_r     = '0;
			stroke_sum  = '0;
			active      = 1'b0;
			stroke_open = 1'b0;
			dist_r      = '0;
			strokes_r   = '0;
			secs_r      = '0;
			predicted_words.delete();
			outstanding = 0;
		end else begin
			// register write word
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MPP:   mpp_r   = cfg.data[15:0];
					REG_PAUSE: pause_r = cfg.data[15:0];
					REG_MINP:  minp_r  = cfg.data[7:0];
					REG_TMO:   tmo_r   = cfg.data[23:0];
					REG_WIN:   win_r   = cfg.data[15:0];
					REG_CAL:   cal_r   = cfg.data[15:0];
					REG_STEP:  step_r  = cfg.data;
					default: begin
					end
				endcase
			end

			// result word against the oldest prediction
			if (result.valid && result.ready) begin
				got.session_active = result.session_active;
				got.session_ended  = result.session_ended;
				got.stroke_done    = result.stroke_done;
				got.stroke_count   = result.stroke_count;
				got.distance_q16   = result.distance_q16;
				got.calories_q16   = result.calories_q16;
				got.total_pulses   = result.total_pulses;
				got.speed_q16      = result.speed_q16;
				got.max_speed_q16  = result.max_speed_q16;
				got.lit_leds       = result.lit_leds;
				got.effort_band    = result.effort_band;
				got.duration_s     = result.duration_s;
				if (predicted_words.size() == 0) begin
					report_mismatch("result word with nothing pending", 64'(got), 64'd0);
				end else begin
					want = predicted_words.pop_front();
					if (got.session_active !== want.session_active)
						report_mismatch("session_active", 64'(got.session_active),
							64'(want.session_active));
					if (got.session_ended !== want.session_ended)
						report_mismatch("session_ended", 64'(got.session_ended),
							64'(want.session_ended));
					if (got.stroke_done !== want.stroke_done)
						report_mismatch("stroke_done", 64'(got.stroke_done),
							64'(want.stroke_done));
					if (got.stroke_count !== want.stroke_count)
						report_mismatch("stroke_count", 64'(got.stroke_count),
							64'(want.stroke_count));
					if (got.distance_q16 !== want.distance_q16)
						report_mismatch("distance_q16", 64'(got.distance_q16),
							64'(want.distance_q16));
					if (got.calories_q16 !== want.calories_q16)
						report_mismatch("calories_q16", 64'(got.calories_q16),
							64'(want.calories_q16));
					if (got.total_pulses !== want.total_pulses)
						report_mismatch("total_pulses", 64'(got.total_pulses),
							64'(want.total_pulses));
					if (got.speed_q16 !== want.speed_q16)
						report_mismatch("speed_q16", 64'(got.speed_q16),
							64'(want.speed_q16));
					if (got.max_speed_q16 !== want.max_speed_q16)
						report_mismatch("max_speed_q16", 64'(got.max_speed_q16),
							64'(want.max_speed_q16));
					if (got.lit_leds !== want.lit_leds)
						report_mismatch("lit_leds", 64'(got.lit_leds), 64'(want.lit_leds));
					if (got.effort_band !== want.effort_band)
						report_mismatch("effort_band", 64'(got.effort_band),
							64'(want.effort_band));
					if (got.duration_s !== want.duration_s)
						report_mismatch("duration_s", 64'(got.duration_s),
							64'(want.duration_s));
					words_checked++;
					if (want.session_ended) sessions_closed++;
					if (want.stroke_done) strokes_counted++;
				end
			end

			// sample word
			if (sample.valid && sample.ready) begin
				predicted_words.push_back(advance_session(sample.time_ms, sample.position));
			end
			outstanding = predicted_words.size();
		end
	end

endmodule

>>> verif/tb_encoder_stroke_session_monitor_top.sv
`timescale 1ns / 1ps

module tb_encoder_stroke_session_monitor_top;
	import esm_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 12;
	localparam int TARGET_SAMPLES = 1025;
	localparam int PHASE_SAMPLES  = 100;

	// index past the register map, the block ignores it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	esm_in_if  sample_ch();
	esm_out_if result_ch();
	esm_cfg_if cfg_ch();

	int failures, outstanding, words_checked, sessions_closed, strokes_counted;
	int samples_sent, settings_used, idle_run, phase, phase_start;
	bit no_gaps, hold_request;

	// stimulus timeline and the settings that shape it
	logic [31:0] now_ms, enc_pos;
	logic [15:0] pause_set;
	logic [23:0] timeout_set;

	encoder_stroke_session_monitor_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	esm_session_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample          (sample_ch),
		.result          (result_ch),
		.cfg             (cfg_ch),
		.failures        (failures),
		.outstanding     (outstanding),
		.words_checked   (words_checked),
		.sessions_closed (sessions_closed),
		.strokes_counted (strokes_counted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_value(input logic [31:0] lo_ext,
		input logic [31:0] hi_ext, input logic [31:0] lo, input logic [31:0] hi);
		if ($urandom_range(0, 99) < 12) return $urandom_range(0, 1) ? hi_ext : lo_ext;
		return $urandom_range(lo, hi);
	endfunction

	task automatic send_sample(input logic [31:0] t, input logic [31:0] p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.time_ms  <= t;
		sample_ch.position <= p;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		samples_sent++;
	endtask

	task automatic move_encoder(input logic [31:0] dt, input logic [31:0] dp);
		now_ms  = now_ms + dt;
		enc_pos = enc_pos + dp;
		send_sample(now_ms, enc_pos);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_PAUSE) pause_set = val[15:0];
		if (idx == REG_TMO) timeout_set = val[23:0];
		@(posedge clk);
	endtask

	// drain every pending word, then let the pipeline empty
	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic randomize_settings();
		write_reg(REG_MPP, pick_value(0, 65535, 500, 8000));
		write_reg(REG_PAUSE, pick_value(0, 65535, 20, 600));
		write_reg(REG_MINP, pick_value(0, 255, 0, 12));
		write_reg(REG_TMO, pick_value(0, 24'hFF_FFFF, 200, 5000));
		write_reg(REG_WIN, pick_value(1, 65535, 20, 1500));
		write_reg(REG_CAL, pick_value(0, 65535, 0, 65535));
		write_reg(REG_STEP, pick_value(1, 32'hFFFF_FFFF, 2000, 80000));
		settings_used++;
	endtask

	// strokes of forward pulses, pauses, and usually a timeout at the end
	task automatic play_session();
		int          strokes, moves, stills, r;
		logic [31:0] dp;
		if ($urandom_range(0, 3) == 0) enc_pos = $urandom();
		move_encoder($urandom_range(1, 100), $urandom_range(1, 50));
		strokes = $urandom_range(1, 6);
		repeat (strokes) begin
			moves = $urandom_range(1, 10);
			repeat (moves) begin
				r = $urandom_range(0, 99);
				if (r < 6) dp = 32'd0 - $urandom_range(1, 30);
				else if (r < 9) dp = $urandom();
				else dp = $urandom_range(1, 9);
				move_encoder($urandom_range(0, 60), dp);
			end
			stills = $urandom_range(0, 3);
			repeat (stills) move_encoder($urandom_range(0, pause_set / 2 + 10), 32'd0);
			move_encoder(pause_set + $urandom_range(0, 40), 32'd0);
		end
		r = $urandom_range(0, 9);
		if (r < 6) move_encoder(timeout_set + 1 + $urandom_range(0, 300), 32'd0);
		else if (r < 8) move_encoder(timeout_set + $urandom_range(0, 1), 32'd0);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				if (pick_gap() > 0) begin
					result_ch.ready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (sample_ch.valid && sample_ch.ready) ||
			(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			idle_run <= 0;
		end else if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word accepted for %0d cycles", idle_run);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		sample_ch.valid    <= 1'b0;
		sample_ch.time_ms  <= '0;
		sample_ch.position <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= REG_MPP;
		cfg_ch.data        <= '0;
		idle_run            = 0;
		samples_sent        = 0;
		settings_used       = 1;
		no_gaps             = 1'b0;
		hold_request        = 1'b0;
		now_ms              = '0;
		enc_pos             = '0;
		pause_set           = PAUSE_RST;
		timeout_set         = TMO_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: start, forward, backward, pauses, speed, timeout
		send_sample(32'd0, 32'd0);
		send_sample(32'd10, 32'd5);
		send_sample(32'd20, 32'd10);
		send_sample(32'd30, 32'd8);
		send_sample(32'd40, 32'd8);
		send_sample(32'd400, 32'd8);
		send_sample(32'd410, 32'd20);
		send_sample(32'd1100, 32'd30);
		send_sample(32'd1500, 32'd30);
		send_sample(32'd1600, 32'd40);
		send_sample(32'd40000, 32'd40);
		send_sample(32'd40010, 32'd40);

		// top settings, zero led step: saturation, time wrap, timeout closes a stroke
		settle();
		write_reg(REG_MPP, 32'd65535);
		write_reg(REG_PAUSE, 32'd65535);
		write_reg(REG_MINP, 32'd255);
		write_reg(REG_TMO, 32'd1000);
		write_reg(REG_WIN, 32'd1);
		write_reg(REG_CAL, 32'd65535);
		write_reg(REG_STEP, 32'd0);
		settings_used++;
		send_sample(32'hFFFF_FFF0, 32'h8000_0000);
		send_sample(32'hFFFF_FFFA, 32'hFFFF_FFFF);
		send_sample(32'd5, 32'h7FFF_FFFE);
		send_sample(32'd20, 32'hFFFF_FFFD);
		send_sample(32'd25, 32'h8000_0000);
		send_sample(32'd2000, 32'h8000_0000);

		// bottom settings: immediate pause and timeout, no distance, widest led step
		settle();
		write_reg(REG_MPP, 32'd0);
		write_reg(REG_PAUSE, 32'd0);
		write_reg(REG_MINP, 32'd0);
		write_reg(REG_TMO, 32'd0);
		write_reg(REG_WIN, 32'd65535);
		write_reg(REG_CAL, 32'd0);
		write_reg(REG_STEP, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		settings_used++;
		send_sample(32'd100, 32'hFFFF_FFFB);
		send_sample(32'd100, 32'hFFFF_FFFD);
		send_sample(32'd100, 32'hFFFF_FFFD);
		send_sample(32'd101, 32'hFFFF_FFFD);

		// random sessions under a new setting per phase
		phase = 0;
		while (samples_sent < TARGET_SAMPLES) begin
			settle();
			randomize_settings();
			no_gaps = (phase % 4 == 3);
			if (phase == 1 || phase == 6) hold_request = 1'b1;
			if (phase % 3 == 2) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			else now_ms = $urandom();
			phase_start = samples_sent;
			while (samples_sent - phase_start < PHASE_SAMPLES) play_session();
			phase++;
		end

		settle();
		$display("run: %0d samples sent, %0d result words checked, %0d register settings",
			samples_sent, words_checked, settings_used);
		$display("run: %0d sessions ended by inactivity, %0d strokes counted",
			sessions_closed, strokes_counted);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/esm_pkg.sv
sv/esm_ifs.sv
sv/esm_ctrl.sv
sv/esm_dp.sv
sv/encoder_stroke_session_monitor_top.sv
verif/esm_session_checker.sv
verif/tb_encoder_stroke_session_monitor_top.sv
